// ----- sv/utf8sd_pkg.sv -----
package utf8sd_pkg;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned ShiftW = 5;

  // Each continuation byte carries six payload bits.
  localparam logic [ShiftW-1:0] PayloadBits = ShiftW'(6);

  // Result of looking at a byte as a lead byte.
  typedef struct packed {
    logic              is_lead;
    logic [ShiftW-1:0] shift;
    logic [CpW-1:0]    partial;
  } lead_info_t;

  // Classify a lead byte: payload bits placed at the position of the first group.
  function automatic lead_info_t lead_decode(input logic [ByteW-1:0] b);
    lead_info_t info;
    info.is_lead = 1'b1;
    info.shift   = '0;
    info.partial = '0;
    case (b) inside
      8'b110?????: begin
        info.shift   = ShiftW'(6);
        info.partial = CpW'(b[4:0]) << info.shift;
      end
      8'b1110????: begin
        info.shift   = ShiftW'(12);
        info.partial = CpW'(b[3:0]) << info.shift;
      end
      8'b11110???: begin
        info.shift   = ShiftW'(18);
        info.partial = CpW'(b[2:0]) << info.shift;
      end
      8'b111110??: begin
        info.shift   = ShiftW'(24);
        info.partial = CpW'(b[1:0]) << info.shift;
      end
      8'b1111110?: begin
        info.shift   = ShiftW'(30);
        info.partial = CpW'(b[0]) << info.shift;
      end
      default: begin
        info.is_lead = 1'b0;
      end
    endcase
    return info;
  endfunction

endpackage

// ----- sv/utf8_stream_decoder_core.sv -----
// A byte accepted into the input register passes to the decoder and, once it completes a
// code point, that code point is held in the result register, from which it can be taken.
// Throughput: one byte per cycle; in_stall rises only while both the input register and the
// result register hold a word and out_stall is high.
// The decoder state is updated in the single cycle in which a byte moves from the input
// register into the result stage.
// Reset (rst, synchronous, active high) empties both registers and returns the decoder to idle.
module utf8_stream_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [utf8sd_pkg::ByteW-1:0] byte_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [utf8sd_pkg::CpW-1:0]   code_point
);

  // Input register.
  logic                         in_full;
  logic [utf8sd_pkg::ByteW-1:0] in_byte;

  // Decoder state.
  logic                          in_sequence;
  logic [utf8sd_pkg::ShiftW-1:0] shift;
  logic [utf8sd_pkg::CpW-1:0]    partial_char;

  logic                          in_sequence_next;
  logic [utf8sd_pkg::ShiftW-1:0] shift_next;
  logic [utf8sd_pkg::CpW-1:0]    partial_char_next;
  logic                          emit;
  logic [utf8sd_pkg::CpW-1:0]    emit_value;

  logic                          advance;
  utf8sd_pkg::lead_info_t        lead;
  logic [utf8sd_pkg::ShiftW-1:0] cont_shift;
  logic [utf8sd_pkg::CpW-1:0]    cont_char;

  // The held byte moves on whenever the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  assign lead = utf8sd_pkg::lead_decode(in_byte);

  // Continuation: step the shift down one group and merge six payload bits.
  always_comb begin
    if (shift >= utf8sd_pkg::PayloadBits) begin
      cont_shift = shift - utf8sd_pkg::PayloadBits;
    end else begin
      cont_shift = '0;
    end
    cont_char = partial_char | (utf8sd_pkg::CpW'(in_byte[5:0]) << cont_shift);
  end

  // Next decoder state and the result, if any, for the held byte.
  always_comb begin
    in_sequence_next  = in_sequence;
    shift_next        = shift;
    partial_char_next = partial_char;
    emit              = 1'b0;
    emit_value        = utf8sd_pkg::CpW'(in_byte);
    if (!in_sequence) begin
      if (!in_byte[7]) begin
        emit = 1'b1;
      end else if (lead.is_lead) begin
        in_sequence_next  = 1'b1;
        shift_next        = lead.shift;
        partial_char_next = lead.partial;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      // A broken sequence drops the byte and returns to idle.
      in_sequence_next = 1'b0;
    end else begin
      shift_next        = cont_shift;
      partial_char_next = cont_char;
      if (cont_shift == '0) begin
        in_sequence_next = 1'b0;
        emit             = 1'b1;
        emit_value       = cont_char;
      end
    end
  end

  // Input register: holds one word until the decoder takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= byte_in;
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sequence  <= 1'b0;
      shift        <= '0;
      partial_char <= '0;
    end else if (advance) begin
      in_sequence  <= in_sequence_next;
      shift        <= shift_next;
      partial_char <= partial_char_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      code_point <= emit_value;
    end
  end

endmodule
